/* hw/rtl/nsf_pkg.sv */
// Shared types, constants and helpers for the NMEA sentence framer.
// Used by nsf_core and nmea_sentence_framer_unit; depends on nothing.
package nsf_pkg;

    localparam int POS_W   = 10;
    localparam int FIELD_W = 7;

    localparam logic [POS_W-1:0]   MAX_SENTENCE = POS_W'(1000);
    localparam logic [FIELD_W-1:0] MAX_FIELDS   = FIELD_W'(118);

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;

    // Sentence type codes as three ASCII characters.
    localparam logic [23:0] HDR_GGA = 24'h474741;
    localparam logic [23:0] HDR_RMC = 24'h524D43;
    localparam logic [23:0] HDR_GSV = 24'h475356;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_GGA  = 2'd1,
        KIND_RMC  = 2'd2,
        KIND_GSV  = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_HEADER  = 3'd1,
        PH_BODY    = 3'd2,
        PH_CSUM_HI = 3'd3,
        PH_CSUM_LO = 3'd4,
        PH_CR      = 3'd5,
        PH_LF      = 3'd6
    } t_phase;

    typedef struct packed {
        logic [POS_W-1:0]   byte_pos;
        logic               in_sentence;
        logic               field_mark;
        logic [FIELD_W-1:0] field_number;
        logic               sentence_done;
        logic               checksum_bad;
        t_kind              sentence_kind;
        logic [POS_W-1:0]   sentence_length;
        logic [FIELD_W-1:0] field_total;
    } t_result;

    // Hex digit value; anything that is not a hex digit counts as zero.
    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = 4'(c - 8'h30);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = 4'(c - 8'h37);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            v = 4'(c - 8'h57);
        end
        return v;
    endfunction

endpackage

/* hw/rtl/nmea_sentence_framer_unit.sv */
// Top level of the NMEA 0183 sentence framer: input register, step core, result register.
// Depends on nsf_pkg and nsf_core.
//
//  channel | valid       | stall       | payload
//  --------+-------------+-------------+-------------------------------------------
//  in      | i_in_valid  | o_in_stall  | i_rx_byte
//  out     | o_out_valid | i_out_stall | o_byte_pos ... o_field_total (9 fields)
//
// One byte per cycle sustained while i_out_stall is low; the result of a transaction is
// loaded into the result register after acceptance and can be taken from there
// (input register, then result register).
// The framer state advances only when a byte moves from the input register
// into the result register, so stalls freeze the parser with nothing lost.
// A stalled result holds while the input register still takes one more byte.
// Reset (synchronous, active low) empties both registers and returns to hunting for '$'.
module nmea_sentence_framer_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [7:0]                  i_rx_byte,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [nsf_pkg::POS_W-1:0]   o_byte_pos,
    output logic                        o_in_sentence,
    output logic                        o_field_mark,
    output logic [nsf_pkg::FIELD_W-1:0] o_field_number,
    output logic                        o_sentence_done,
    output logic                        o_checksum_bad,
    output logic [1:0]                  o_sentence_kind,
    output logic [nsf_pkg::POS_W-1:0]   o_sentence_length,
    output logic [nsf_pkg::FIELD_W-1:0] o_field_total
);

    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             r_out_valid;
    nsf_pkg::t_result r_out;
    nsf_pkg::t_result step_res;
    logic             advance;
    logic             in_accept;

    // Advance a byte into the result register whenever that register is free
    // or being drained this cycle.
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    nsf_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_byte   (r_in_byte),
        .o_result (step_res)
    );

    // Input register: hold the byte until the core consumes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_byte <= i_rx_byte;
        end
    end

    // Result register: load on advance, drop once the transaction is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= step_res;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_byte_pos        = r_out.byte_pos;
    assign o_in_sentence     = r_out.in_sentence;
    assign o_field_mark      = r_out.field_mark;
    assign o_field_number    = r_out.field_number;
    assign o_sentence_done   = r_out.sentence_done;
    assign o_checksum_bad    = r_out.checksum_bad;
    assign o_sentence_kind   = r_out.sentence_kind;
    assign o_sentence_length = r_out.sentence_length;
    assign o_field_total     = r_out.field_total;

endmodule

/* hw/rtl/nsf_core.sv */
// Framer state registers and per-byte step logic.
// Depends on nsf_pkg; instantiated by nmea_sentence_framer_unit.
module nsf_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic [7:0]       i_byte,
    output nsf_pkg::t_result o_result
);

    nsf_pkg::t_phase                r_phase, n_phase;
    logic [nsf_pkg::POS_W-1:0]      r_byte_count, n_byte_count;
    logic [nsf_pkg::FIELD_W-1:0]    r_comma_count, n_comma_count;
    logic [7:0]                     r_running_xor, n_running_xor;
    logic [7:0]                     r_rcv_csum, n_rcv_csum;
    logic [15:0]                    r_header_chars, n_header_chars;
    nsf_pkg::t_kind                 r_kind, n_kind;

    nsf_pkg::t_phase                phase_eff;
    logic [nsf_pkg::POS_W-1:0]      pos;
    logic [nsf_pkg::FIELD_W-1:0]    comma_eff;
    logic [23:0]                    ahead;
    nsf_pkg::t_result               res;

    always_comb begin
        n_phase        = r_phase;
        n_comma_count  = r_comma_count;
        n_running_xor  = r_running_xor;
        n_rcv_csum     = r_rcv_csum;
        n_header_chars = r_header_chars;
        n_kind         = r_kind;
        phase_eff      = r_phase;
        comma_eff      = r_comma_count;
        pos            = r_byte_count;
        ahead          = {r_header_chars, i_byte};
        res            = '0;

        // Drop an overlong sentence before the byte is looked at.
        if (r_byte_count > nsf_pkg::MAX_SENTENCE) begin
            phase_eff = nsf_pkg::PH_HUNT;
            comma_eff = '0;
            pos       = '0;
        end
        n_phase       = phase_eff;
        n_comma_count = comma_eff;
        n_byte_count  = pos + nsf_pkg::POS_W'(1);
        res.byte_pos    = pos;
        res.in_sentence = 1'b1;

        unique case (phase_eff)
            nsf_pkg::PH_HUNT: begin
                if (i_byte == nsf_pkg::CH_DOLLAR) begin
                    n_phase       = nsf_pkg::PH_HEADER;
                    n_running_xor = '0;
                end else begin
                    n_byte_count    = '0;
                    res.in_sentence = 1'b0;
                end
            end
            nsf_pkg::PH_HEADER: begin
                if (pos == nsf_pkg::POS_W'(3)) begin
                    n_header_chars = {i_byte, r_header_chars[7:0]};
                end else if (pos == nsf_pkg::POS_W'(4)) begin
                    n_header_chars = {r_header_chars[15:8], i_byte};
                end
                if (pos == nsf_pkg::POS_W'(5)) begin
                    if (ahead == nsf_pkg::HDR_GGA || ahead == nsf_pkg::HDR_RMC ||
                        ahead == nsf_pkg::HDR_GSV) begin
                        n_phase       = nsf_pkg::PH_BODY;
                        n_running_xor = r_running_xor ^ i_byte;
                        if (ahead == nsf_pkg::HDR_GGA) begin
                            n_kind = nsf_pkg::KIND_GGA;
                        end else if (ahead == nsf_pkg::HDR_RMC) begin
                            n_kind = nsf_pkg::KIND_RMC;
                        end else begin
                            n_kind = nsf_pkg::KIND_GSV;
                        end
                    end else begin
                        n_phase         = nsf_pkg::PH_HUNT;
                        n_byte_count    = '0;
                        n_comma_count   = '0;
                        res.in_sentence = 1'b0;
                    end
                end else begin
                    n_running_xor = r_running_xor ^ i_byte;
                end
            end
            nsf_pkg::PH_BODY: begin
                if (i_byte == nsf_pkg::CH_STAR) begin
                    n_phase    = nsf_pkg::PH_CSUM_HI;
                    n_rcv_csum = '0;
                end else begin
                    n_running_xor = r_running_xor ^ i_byte;
                    if (i_byte == nsf_pkg::CH_COMMA) begin
                        n_comma_count = comma_eff + nsf_pkg::FIELD_W'(1);
                        if (n_comma_count > nsf_pkg::MAX_FIELDS) begin
                            n_phase         = nsf_pkg::PH_HUNT;
                            n_byte_count    = '0;
                            n_comma_count   = '0;
                            res.in_sentence = 1'b0;
                        end else begin
                            res.field_mark   = 1'b1;
                            res.field_number = comma_eff;
                        end
                    end
                end
            end
            nsf_pkg::PH_CSUM_HI: begin
                n_rcv_csum = {nsf_pkg::hex_value(i_byte), 4'h0};
                n_phase    = nsf_pkg::PH_CSUM_LO;
            end
            nsf_pkg::PH_CSUM_LO: begin
                n_rcv_csum = r_rcv_csum + {4'h0, nsf_pkg::hex_value(i_byte)};
                n_phase    = nsf_pkg::PH_CR;
            end
            nsf_pkg::PH_CR: begin
                if (i_byte == nsf_pkg::CH_CR) begin
                    n_phase = nsf_pkg::PH_LF;
                end else begin
                    n_phase         = nsf_pkg::PH_HUNT;
                    n_byte_count    = '0;
                    n_comma_count   = '0;
                    res.in_sentence = 1'b0;
                end
            end
            default: begin
                // LF slot: close the sentence either way.
                n_phase       = nsf_pkg::PH_HUNT;
                n_byte_count  = '0;
                n_comma_count = '0;
                if (i_byte == nsf_pkg::CH_LF) begin
                    res.sentence_done   = (r_running_xor == r_rcv_csum);
                    res.checksum_bad    = (r_running_xor != r_rcv_csum);
                    res.sentence_kind   = r_kind;
                    res.sentence_length = pos + nsf_pkg::POS_W'(1);
                    res.field_total     = comma_eff;
                end else begin
                    res.in_sentence = 1'b0;
                end
            end
        endcase
    end

    assign o_result = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= nsf_pkg::PH_HUNT;
            r_byte_count  <= '0;
            r_comma_count <= '0;
            r_running_xor <= '0;
            r_rcv_csum    <= '0;
            r_kind        <= nsf_pkg::KIND_NONE;
        end else if (i_step) begin
            r_phase       <= n_phase;
            r_byte_count  <= n_byte_count;
            r_comma_count <= n_comma_count;
            r_running_xor <= n_running_xor;
            r_rcv_csum    <= n_rcv_csum;
            r_kind        <= n_kind;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_header_chars <= n_header_chars;
        end
    end

endmodule
